/* src/hrfd_pkg.sv */
// Package for the HTTP response framing detector: types, character codes and name tables.
`default_nettype none
package hrfd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;

  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;
  localparam logic [POS_W-1:0] CL_LEN = 5'd14;
  localparam logic [POS_W-1:0] TE_LEN = 5'd17;

  // scan state of a Content-Length value, kept in the position register
  localparam logic [POS_W-1:0] SCAN_SKIP = 5'd0;
  localparam logic [POS_W-1:0] SCAN_DIGITS = 5'd1;
  localparam logic [POS_W-1:0] SCAN_STOPPED = 5'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // "0" CR LF CR LF
  localparam logic [39:0] TAIL_MAGIC = 40'h300D0A0D0A;

  typedef enum logic [3:0] {
    PH_NAME  = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    FRM_UNKNOWN = 2'd0,
    FRM_CHUNKED = 2'd1,
    FRM_LENGTH  = 2'd2
  } framing_e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] framing;
    logic       header_end;
    logic       in_body;
    logic       response_done;
    logic       length_overflow;
  } result_t;

  function automatic logic [7:0] cl_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = "C";
      5'd1:    c = "o";
      5'd2:    c = "n";
      5'd3:    c = "t";
      5'd4:    c = "e";
      5'd5:    c = "n";
      5'd6:    c = "t";
      5'd7:    c = "-";
      5'd8:    c = "L";
      5'd9:    c = "e";
      5'd10:   c = "n";
      5'd11:   c = "g";
      5'd12:   c = "t";
      5'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] te_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = "T";
      5'd1:    c = "r";
      5'd2:    c = "a";
      5'd3:    c = "n";
      5'd4:    c = "s";
      5'd5:    c = "f";
      5'd6:    c = "e";
      5'd7:    c = "r";
      5'd8:    c = "-";
      5'd9:    c = "E";
      5'd10:   c = "n";
      5'd11:   c = "c";
      5'd12:   c = "o";
      5'd13:   c = "d";
      5'd14:   c = "i";
      5'd15:   c = "n";
      5'd16:   c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/hrfd_len_acc.sv */
// Decimal length accumulator: value * 10 + digit, saturating at all ones.
`default_nettype none
module hrfd_len_acc #(
  parameter int unsigned LENGTH_BITS = hrfd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic [LENGTH_BITS-1:0] len_i,
  input  wire logic [3:0]             digit_i,
  output logic      [LENGTH_BITS-1:0] len_o,
  output logic                        ovf_o
);

  logic [LENGTH_BITS+3:0] wide;

  // x*10 as x*8 + x*2
  assign wide = ({4'b0000, len_i} << 3) + ({4'b0000, len_i} << 1)
              + {{LENGTH_BITS{1'b0}}, digit_i};
  assign ovf_o = |wide[LENGTH_BITS+3:LENGTH_BITS];
  assign len_o = ovf_o ? {LENGTH_BITS{1'b1}} : wide[LENGTH_BITS-1:0];

endmodule
`default_nettype wire

/* src/hrfd_step.sv */
// Parser state and the per-word update of the framing detector.
`default_nettype none
module hrfd_step #(
  parameter int unsigned LENGTH_BITS = hrfd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [7:0]       data_i,
  input  wire logic             sor_i,
  output hrfd_pkg::result_t     res_o
);

  hrfd_pkg::phase_e   phase_q, phase_d, cur_phase;
  logic [hrfd_pkg::POS_W-1:0] pos_q, pos_d, cur_pos;
  logic               lm_q, lm_d, cur_lm;
  logic               em_q, em_d, cur_em;
  hrfd_pkg::framing_e kind_q, kind_d, cur_kind;
  logic               empty_q, empty_d, cur_empty;
  logic               cr_q, cr_d, cur_cr;
  logic [LENGTH_BITS-1:0] len_q, len_d, cur_len;
  logic               cap_q, cap_d, cur_cap;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cur_cnt;
  logic [39:0]        tail_q, tail_d, cur_tail;
  logic               sat_q, sat_d, cur_sat;

  logic [LENGTH_BITS-1:0] acc_len;
  logic               acc_ovf;
  logic               is_digit;
  logic               hend, body, done;

  assign is_digit = (data_i >= hrfd_pkg::CHAR_ZERO) && (data_i <= hrfd_pkg::CHAR_NINE);

  hrfd_len_acc #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_len_acc (
    .len_i  (cur_len),
    .digit_i(data_i[3:0]),
    .len_o  (acc_len),
    .ovf_o  (acc_ovf)
  );

  always_comb begin
    cur_phase = sor_i ? hrfd_pkg::PH_NAME : phase_q;
    cur_pos   = sor_i ? '0 : pos_q;
    cur_lm    = sor_i ? 1'b1 : lm_q;
    cur_em    = sor_i ? 1'b1 : em_q;
    cur_kind  = sor_i ? hrfd_pkg::FRM_UNKNOWN : kind_q;
    cur_empty = sor_i ? 1'b1 : empty_q;
    cur_cr    = sor_i ? 1'b0 : cr_q;
    cur_len   = sor_i ? '0 : len_q;
    cur_cap   = sor_i ? 1'b0 : cap_q;
    cur_cnt   = sor_i ? '0 : cnt_q;
    cur_tail  = sor_i ? '0 : tail_q;
    cur_sat   = sor_i ? 1'b0 : sat_q;
  end

  always_comb begin
    phase_d = cur_phase;
    pos_d   = cur_pos;
    lm_d    = cur_lm;
    em_d    = cur_em;
    kind_d  = cur_kind;
    empty_d = cur_empty;
    cr_d    = cur_cr;
    len_d   = cur_len;
    cap_d   = cur_cap;
    cnt_d   = cur_cnt;
    tail_d  = cur_tail;
    sat_d   = cur_sat;
    hend    = 1'b0;
    body    = 1'b0;
    done    = 1'b0;

    unique case (cur_phase) inside
      hrfd_pkg::PH_BODY: begin
        body = 1'b1;
        if (cur_kind == hrfd_pkg::FRM_LENGTH) begin
          if (cur_cnt < cur_len) cnt_d = cur_cnt + 1'b1;
          done = (cnt_d >= cur_len);
        end else if (cur_kind == hrfd_pkg::FRM_CHUNKED) begin
          tail_d = {cur_tail[31:0], data_i};
          done = (tail_d == hrfd_pkg::TAIL_MAGIC);
        end
        if (done) phase_d = hrfd_pkg::PH_DONE;
      end
      hrfd_pkg::PH_DONE: begin
      end
      hrfd_pkg::PH_NAME, hrfd_pkg::PH_VALUE: begin
        if (data_i == hrfd_pkg::CHAR_CR) begin
          cr_d = 1'b1;
        end else if (data_i == hrfd_pkg::CHAR_LF && cur_cr) begin
          cr_d = 1'b0;
          if (cur_phase == hrfd_pkg::PH_NAME && cur_empty) begin
            hend    = 1'b1;
            phase_d = hrfd_pkg::PH_BODY;
            cnt_d   = '0;
            tail_d  = '0;
            if (cur_kind == hrfd_pkg::FRM_LENGTH && cur_len == '0) begin
              done    = 1'b1;
              phase_d = hrfd_pkg::PH_DONE;
            end
          end else begin
            if (cur_phase == hrfd_pkg::PH_VALUE && cur_lm) cap_d = 1'b1;
            phase_d = hrfd_pkg::PH_NAME;
            pos_d   = '0;
            lm_d    = 1'b1;
            em_d    = 1'b1;
            empty_d = 1'b1;
          end
        end else begin
          cr_d    = 1'b0;
          empty_d = 1'b0;
          if (cur_phase == hrfd_pkg::PH_NAME) begin
            if (data_i == hrfd_pkg::CHAR_COLON) begin
              lm_d = cur_lm && (cur_pos == hrfd_pkg::CL_LEN);
              em_d = cur_em && (cur_pos == hrfd_pkg::TE_LEN);
              if (em_d) kind_d = hrfd_pkg::FRM_CHUNKED;
              else if (lm_d && cur_kind != hrfd_pkg::FRM_CHUNKED)
                kind_d = hrfd_pkg::FRM_LENGTH;
              phase_d = hrfd_pkg::PH_VALUE;
              pos_d   = '0;
            end else begin
              lm_d = cur_lm && (cur_pos < hrfd_pkg::CL_LEN)
                   && (data_i == hrfd_pkg::cl_char(cur_pos));
              em_d = cur_em && (cur_pos < hrfd_pkg::TE_LEN)
                   && (data_i == hrfd_pkg::te_char(cur_pos));
              if (cur_pos < hrfd_pkg::POS_MAX) pos_d = cur_pos + 1'b1;
            end
          end else if (cur_lm && !cur_cap) begin
            if (cur_pos == hrfd_pkg::SCAN_SKIP) begin
              if (data_i != hrfd_pkg::CHAR_SPACE) begin
                if (is_digit) begin
                  len_d = acc_len;
                  sat_d = cur_sat | acc_ovf;
                  pos_d = hrfd_pkg::SCAN_DIGITS;
                end else begin
                  pos_d = hrfd_pkg::SCAN_STOPPED;
                end
              end
            end else if (cur_pos == hrfd_pkg::SCAN_DIGITS) begin
              if (is_digit) begin
                len_d = acc_len;
                sat_d = cur_sat | acc_ovf;
              end else begin
                pos_d = hrfd_pkg::SCAN_STOPPED;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.byte_out        = data_i;
  assign res_o.framing         = kind_d;
  assign res_o.header_end      = hend;
  assign res_o.in_body         = body;
  assign res_o.response_done   = done;
  assign res_o.length_overflow = sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrfd_pkg::PH_NAME;
      pos_q   <= '0;
      lm_q    <= 1'b1;
      em_q    <= 1'b1;
      kind_q  <= hrfd_pkg::FRM_UNKNOWN;
      empty_q <= 1'b1;
      cr_q    <= 1'b0;
      len_q   <= '0;
      cap_q   <= 1'b0;
      cnt_q   <= '0;
      tail_q  <= '0;
      sat_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      lm_q    <= lm_d;
      em_q    <= em_d;
      kind_q  <= kind_d;
      empty_q <= empty_d;
      cr_q    <= cr_d;
      len_q   <= len_d;
      cap_q   <= cap_d;
      cnt_q   <= cnt_d;
      tail_q  <= tail_d;
      sat_q   <= sat_d;
    end
  end

endmodule
`default_nettype wire

/* src/http_response_framing_detector.sv */
// Top level of the HTTP response framing detector: input register, step logic, result register.
// Takes one response byte per word and returns one result word per byte, passing the byte
// through with the framing (unknown, chunked or content length), header end, body, done and
// length overflow flags. A word is registered on input, parsed against the parser state and
// registered on output, so the block sustains one byte per clock while the output is not
// stalled; a stalled output holds the result while the input register still takes one more
// word. start_of_response clears the parser before its byte is parsed. LENGTH_BITS sets the
// width of the Content-Length value and the body byte counter.
`default_nettype none
module http_response_framing_detector #(
  parameter int unsigned LENGTH_BITS = hrfd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       start_of_response_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      byte_out_o,
  output logic [1:0]      framing_o,
  output logic            header_end_o,
  output logic            in_body_o,
  output logic            response_done_o,
  output logic            length_overflow_o
);

  logic              in_valid_q;
  logic [7:0]        data_q;
  logic              sor_q;
  logic              out_valid_q;
  hrfd_pkg::result_t res_d, res_q;
  logic              advance;
  logic              in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  hrfd_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (advance),
    .data_i(data_q),
    .sor_i (sor_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q <= data_byte_i;
      sor_q  <= start_of_response_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o       = out_valid_q;
  assign byte_out_o        = res_q.byte_out;
  assign framing_o         = res_q.framing;
  assign header_end_o      = res_q.header_end;
  assign in_body_o         = res_q.in_body;
  assign response_done_o   = res_q.response_done;
  assign length_overflow_o = res_q.length_overflow;

endmodule
`default_nettype wire
